// File: hw/rtl/fqs_pkg.sv
// ----------------------------------------------------------------------------
// fqs_pkg: shared types and constants for the searchable queue
// Queue depth, field widths, request and status codes, cell control bundle.
// ----------------------------------------------------------------------------
package fqs_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int DATA_W      = 32;
  localparam int POS_W       = 4;
  localparam int ACT_W       = 2;
  localparam int STAT_W      = 2;
  localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // request codes; code three is ignored
  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_SEARCH = 2'd2
  } action_t;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // controls broadcast to every cell of the row
  typedef struct packed {
    logic              shift;
    logic              search;
    logic [DATA_W-1:0] key;
  } cell_ctl_t;

endpackage

// File: hw/rtl/fqs_cell.sv
// ----------------------------------------------------------------------------
// fqs_cell: one queue slot
// Holds one entry, takes its neighbor's entry on a remove, loads a new entry
// on an insert aimed at it, and registers its own match flag on a search.
// ----------------------------------------------------------------------------
module fqs_cell (
  input  logic                       clk,
  input  fqs_pkg::cell_ctl_t         ctl,
  input  logic                       load,
  input  logic                       occ,
  input  logic [fqs_pkg::DATA_W-1:0] load_data,
  input  logic [fqs_pkg::DATA_W-1:0] neighbor,
  output logic [fqs_pkg::DATA_W-1:0] data,
  output logic                       hit
);

  // entry storage: shift toward the front or load from the request
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      data <= neighbor;
    end else if (load) begin
      data <= load_data;
    end
  end

  // match flag of an occupied slot
  always_ff @(posedge clk) begin
    if (ctl.search) begin
      hit <= occ && (data == ctl.key);
    end
  end

endmodule

// File: hw/rtl/fqs_first_hit.sv
// ----------------------------------------------------------------------------
// fqs_first_hit: front-most match encoder
// Turns the registered match flags of the row into the index of the first
// match counted from the front, plus a flag that any slot matched.
// ----------------------------------------------------------------------------
module fqs_first_hit (
  input  logic [fqs_pkg::QUEUE_DEPTH-1:0] hits,
  output logic                            any,
  output logic [fqs_pkg::IDX_W-1:0]       idx
);

  // lowest set flag wins
  always_comb begin
    idx = '0;
    for (int i = fqs_pkg::QUEUE_DEPTH - 1; i >= 0; i--) begin
      if (hits[i]) begin
        idx = fqs_pkg::IDX_W'(i);
      end
    end
  end

  assign any = |hits;

endmodule

// File: hw/rtl/fifo_queue_with_search.sv
// ----------------------------------------------------------------------------
// fifo_queue_with_search: first-in first-out queue with associative search
// A row of slot cells with the front entry always in the first cell.
// ----------------------------------------------------------------------------
// Usage:
//   Requests come in on in_valid/in_ready with action and value; each request
//   beat gives exactly one result beat on out_valid/out_ready carrying status,
//   removed_value and position.
//   Insert writes the cell just past the last occupied one; remove hands every
//   entry one cell toward the front; search compares the key in every cell at
//   once and registers the match flags.
//   Each request passes the cell update and match flags, then the front-most
//   match encode into the result register. One request is in flight at a time,
//   so the block does not take a new request until the last one has moved
//   into the result register.
//   When the receiver stalls, the result is held; in_ready is low while a
//   request is in flight, so one more request is taken and then the input
//   stalls until the held result beat leaves.
//   Insert into a full queue returns the full status and leaves the queue as
//   it was; remove or search on an empty queue returns the empty status.
//   Reset empties the queue and clears both handshakes; entry contents are
//   not cleared, only the fill count marks which cells hold entries.
// ----------------------------------------------------------------------------
module fifo_queue_with_search (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [fqs_pkg::ACT_W-1:0]         action,
  input  logic signed [fqs_pkg::DATA_W-1:0] value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [fqs_pkg::STAT_W-1:0]        status,
  output logic signed [fqs_pkg::DATA_W-1:0] removed_value,
  output logic [fqs_pkg::POS_W-1:0]         position
);

  localparam int N = fqs_pkg::QUEUE_DEPTH;

  logic [fqs_pkg::CNT_W-1:0]  count;
  logic [fqs_pkg::CNT_W-1:0]  count_next;
  logic                       pend;
  logic                       pend_search;
  fqs_pkg::status_t           pend_status;
  logic [fqs_pkg::DATA_W-1:0] pend_removed;

  logic                       accept;
  logic                       full;
  logic                       empty;
  fqs_pkg::action_t           act;
  fqs_pkg::cell_ctl_t         ctl;
  fqs_pkg::status_t           req_status;
  logic                       do_insert;
  logic                       do_remove;
  logic                       advance;

  logic [fqs_pkg::DATA_W-1:0] cell_data [N];
  logic [N-1:0]               hits;
  logic                       any_hit;
  logic [fqs_pkg::IDX_W-1:0]  hit_idx;

  assign act      = fqs_pkg::action_t'(action);
  assign in_ready = !pend;
  assign accept   = in_valid && in_ready;
  assign full     = (count == fqs_pkg::CNT_W'(N));
  assign empty    = (count == '0);
  assign advance  = pend && (!out_valid || out_ready);

  // request decode: status known at the beat, and the cell controls
  always_comb begin
    req_status = fqs_pkg::ST_OK;
    do_insert  = 1'b0;
    do_remove  = 1'b0;
    ctl.search = 1'b0;
    ctl.key    = value;
    unique case (act)
      fqs_pkg::ACT_INSERT: begin
        if (full) begin
          req_status = fqs_pkg::ST_FULL;
        end else begin
          do_insert = accept;
        end
      end
      fqs_pkg::ACT_REMOVE: begin
        if (empty) begin
          req_status = fqs_pkg::ST_EMPTY;
        end else begin
          do_remove = accept;
        end
      end
      fqs_pkg::ACT_SEARCH: begin
        if (empty) begin
          req_status = fqs_pkg::ST_EMPTY;
        end else begin
          ctl.search = accept;
        end
      end
      default: begin
        req_status = fqs_pkg::ST_OK;
      end
    endcase
    ctl.shift = do_remove;
  end

  // row of slot cells, front entry in cell zero
  for (genvar i = 0; i < N; i++) begin : g_cell
    logic [fqs_pkg::DATA_W-1:0] nb;
    if (i == N - 1) begin : g_last
      assign nb = cell_data[i];
    end else begin : g_mid
      assign nb = cell_data[i+1];
    end
    fqs_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .load      (do_insert && (count == fqs_pkg::CNT_W'(i))),
      .occ       (fqs_pkg::CNT_W'(i) < count),
      .load_data (value),
      .neighbor  (nb),
      .data      (cell_data[i]),
      .hit       (hits[i])
    );
  end

  fqs_first_hit u_first_hit (
    .hits (hits),
    .any  (any_hit),
    .idx  (hit_idx)
  );

  // fill count
  always_comb begin
    count_next = count;
    if (do_insert) begin
      count_next = count + 1'b1;
    end else if (do_remove) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // request in flight between the cell update and the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (accept) begin
      pend <= 1'b1;
    end else if (advance) begin
      pend <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_status  <= req_status;
      pend_search  <= ctl.search;
      pend_removed <= do_remove ? cell_data[0] : '0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      removed_value <= pend_removed;
      if (pend_search && any_hit) begin
        status   <= fqs_pkg::ST_OK;
        position <= fqs_pkg::POS_W'(hit_idx);
      end else if (pend_search) begin
        status   <= fqs_pkg::ST_NOT_FOUND;
        position <= '0;
      end else begin
        status   <= pend_status;
        position <= '0;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= fqs_pkg::CNT_W'(N))
    else $error("fill count beyond queue depth");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    accept |=> pend && !in_ready)
    else $error("request beat did not mark a request in flight");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (pend && !out_valid) |=> out_valid && !pend)
    else $error("pending request did not reach the result register");

  a_remove_count: assert property (@(posedge clk) disable iff (rst)
    do_remove |=> count == $past(count) - 1'b1)
    else $error("remove did not shrink the queue");

  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    (accept && act == fqs_pkg::ACT_INSERT && full) |=> full)
    else $error("dropped insert changed the fill count");
`endif

endmodule
